/* src/stq_pkg.sv */
// shared types, constants and codes for the sorted timer priority queue
// no dependencies; every other file uses this package
`default_nettype none
package stq_pkg;

	// queue geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int ID_W    = 8;
	localparam int MIN_W   = 16;
	localparam int COUNT_W = 5;
	localparam int LIMIT_W = 5;

	// apb port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE_HEAD = 2'd1,
		ACT_REMOVE_ID = 2'd2,
		ACT_SUBTRACT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// register indexes
	typedef enum logic {
		REG_SORT_KEY = 1'b0,
		REG_CAPACITY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [MIN_W-1:0] expire;
		logic [MIN_W-1:0] deliver;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CHK,
		S_INS_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHF_CHK,
		S_SHF_WR,
		S_SUB_CHK,
		S_SUB_WR,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MOVE_UP,
		OP_PLACE,
		OP_TAKE,
		OP_NEXT,
		OP_SHIFT,
		OP_SUB,
		OP_DROP,
		OP_FLAG
	} dp_op_t;

	typedef enum logic [1:0] {
		RD_PREV,
		RD_CUR,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		dp_op_t  op;
		logic    rd_en;
		rd_sel_t rd_sel;
		status_t flag;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		action_t          action;
		logic             full;
		logic             fill_zero;
		logic             idx_zero;
		logic             idx_at_fill;
		logic             next_at_fill;
		logic             key_gt;
		logic             id_match;
		logic [CNT_W-1:0] fill;
	} dp_stat_t;

endpackage
`default_nettype wire

/* src/stq_in_if.sv */
// input channel: one action with its operands
// depends on stq_pkg for field widths
`default_nettype none
interface stq_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic [stq_pkg::ID_W-1:0]       in_id;
	logic [stq_pkg::MIN_W-1:0]      in_expire_min;
	logic [stq_pkg::MIN_W-1:0]      in_deliver_min;
	logic [stq_pkg::MIN_W-1:0]      minutes_delta;
	logic                           time_field;

	modport source (output valid, action, in_id, in_expire_min, in_deliver_min,
		minutes_delta, time_field, input ready);
	modport sink (input valid, action, in_id, in_expire_min, in_deliver_min,
		minutes_delta, time_field, output ready);
endinterface
`default_nettype wire

/* src/stq_out_if.sv */
// output channel: one result per action
// depends on stq_pkg for field widths
`default_nettype none
interface stq_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [stq_pkg::ID_W-1:0]       out_id;
	logic [stq_pkg::MIN_W-1:0]      out_expire_min;
	logic [stq_pkg::MIN_W-1:0]      out_deliver_min;
	logic [stq_pkg::COUNT_W-1:0]    entry_count;

	modport source (output valid, status, out_id, out_expire_min, out_deliver_min,
		entry_count, input ready);
	modport sink (input valid, status, out_id, out_expire_min, out_deliver_min,
		entry_count, output ready);
endinterface
`default_nettype wire

/* src/stq_datapath.sv */
// datapath: entry memory, walk pointer, fill count, item and result registers
// depends on stq_pkg; driven by stq_ctrl commands
`default_nettype none
module stq_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stq_pkg::dp_cmd_t              cmd,
	input  wire logic [1:0]                    action,
	input  wire logic [stq_pkg::ID_W-1:0]      in_id,
	input  wire logic [stq_pkg::MIN_W-1:0]     in_expire_min,
	input  wire logic [stq_pkg::MIN_W-1:0]     in_deliver_min,
	input  wire logic [stq_pkg::MIN_W-1:0]     minutes_delta,
	input  wire logic                          time_field,
	input  wire logic                          sort_key,
	input  wire logic [stq_pkg::LIMIT_W-1:0]   cap_limit,
	output stq_pkg::dp_stat_t                  stat,
	output logic [1:0]                         status,
	output logic [stq_pkg::ID_W-1:0]           out_id,
	output logic [stq_pkg::MIN_W-1:0]          out_expire_min,
	output logic [stq_pkg::MIN_W-1:0]          out_deliver_min,
	output logic [stq_pkg::COUNT_W-1:0]        entry_count
);

	stq_pkg::entry_t                mem_q [stq_pkg::DEPTH];
	stq_pkg::entry_t                rd_q;
	stq_pkg::entry_t                new_entry;
	stq_pkg::entry_t                sub_entry;
	logic [stq_pkg::CNT_W-1:0]      fill_q;
	logic [stq_pkg::CNT_W-1:0]      idx_q;
	logic [stq_pkg::CNT_W-1:0]      rd_addr_full;
	logic [stq_pkg::IDX_W-1:0]      rd_addr;
	logic [stq_pkg::IDX_W-1:0]      wr_addr;
	logic [stq_pkg::CNT_W:0]        cap_eff;
	stq_pkg::action_t               act_q;
	logic [stq_pkg::ID_W-1:0]       id_q;
	logic [stq_pkg::MIN_W-1:0]      exp_q;
	logic [stq_pkg::MIN_W-1:0]      del_q;
	logic [stq_pkg::MIN_W-1:0]      delta_q;
	logic                           field_q;
	stq_pkg::status_t               res_status_q;
	stq_pkg::entry_t                res_entry_q;
	logic [stq_pkg::MIN_W-1:0]      rd_key;
	logic [stq_pkg::MIN_W-1:0]      new_key;
	logic [stq_pkg::MIN_W-1:0]      sub_src;
	logic [stq_pkg::MIN_W-1:0]      sub_val;
	logic [1:0]                     out_status_q;
	stq_pkg::entry_t                out_entry_q;
	logic [stq_pkg::CNT_W-1:0]      out_count_q;

	// read address relative to the walk pointer
	always_comb begin
		case (cmd.rd_sel)
			stq_pkg::RD_PREV: rd_addr_full = idx_q - stq_pkg::CNT_W'(1);
			stq_pkg::RD_NEXT: rd_addr_full = idx_q + stq_pkg::CNT_W'(1);
			default:          rd_addr_full = idx_q;
		endcase
	end
	assign rd_addr = rd_addr_full[stq_pkg::IDX_W-1:0];
	assign wr_addr = idx_q[stq_pkg::IDX_W-1:0];

	// key compare for the insert walk
	assign rd_key  = sort_key ? rd_q.deliver : rd_q.expire;
	assign new_key = sort_key ? del_q : exp_q;
	assign new_entry = '{id: id_q, expire: exp_q, deliver: del_q};

	// saturating subtract of the chosen time field
	assign sub_src = field_q ? rd_q.deliver : rd_q.expire;
	assign sub_val = (sub_src > delta_q) ? sub_src - delta_q : '0;
	always_comb begin
		sub_entry = rd_q;
		if (field_q) begin
			sub_entry.deliver = sub_val;
		end else begin
			sub_entry.expire = sub_val;
		end
	end

	// effective capacity, clipped at the memory depth
	assign cap_eff = ((stq_pkg::CNT_W + 1)'(cap_limit) > (stq_pkg::CNT_W + 1)'(stq_pkg::DEPTH))
		? (stq_pkg::CNT_W + 1)'(stq_pkg::DEPTH) : (stq_pkg::CNT_W + 1)'(cap_limit);

	// status toward the controller
	always_comb begin
		stat.action       = act_q;
		stat.full         = (stq_pkg::CNT_W + 1)'(fill_q) >= cap_eff;
		stat.fill_zero    = fill_q == '0;
		stat.idx_zero     = idx_q == '0;
		stat.idx_at_fill  = idx_q == fill_q;
		stat.next_at_fill = (idx_q + stq_pkg::CNT_W'(1)) >= fill_q;
		stat.key_gt       = rd_key > new_key;
		stat.id_match     = rd_q.id == id_q;
		stat.fill         = fill_q;
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		case (cmd.op)
			stq_pkg::OP_MOVE_UP: mem_q[wr_addr] <= rd_q;
			stq_pkg::OP_PLACE:   mem_q[wr_addr] <= new_entry;
			stq_pkg::OP_SHIFT:   mem_q[wr_addr] <= rd_q;
			stq_pkg::OP_SUB:     mem_q[wr_addr] <= sub_entry;
			default: ;
		endcase
	end

	// walk pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			case (cmd.op)
				stq_pkg::OP_LOAD: begin
					idx_q <= (stq_pkg::action_t'(action) == stq_pkg::ACT_INSERT) ? fill_q : '0;
				end
				stq_pkg::OP_MOVE_UP: idx_q <= idx_q - stq_pkg::CNT_W'(1);
				stq_pkg::OP_PLACE:   fill_q <= fill_q + stq_pkg::CNT_W'(1);
				stq_pkg::OP_NEXT,
				stq_pkg::OP_SHIFT,
				stq_pkg::OP_SUB:     idx_q <= idx_q + stq_pkg::CNT_W'(1);
				stq_pkg::OP_DROP:    fill_q <= fill_q - stq_pkg::CNT_W'(1);
				default: ;
			endcase
		end
	end

	// item operands and result under construction
	always_ff @(posedge clk) begin
		case (cmd.op)
			stq_pkg::OP_LOAD: begin
				act_q        <= stq_pkg::action_t'(action);
				id_q         <= in_id;
				exp_q        <= in_expire_min;
				del_q        <= in_deliver_min;
				delta_q      <= minutes_delta;
				field_q      <= time_field;
				res_status_q <= stq_pkg::ST_OK;
				res_entry_q  <= '0;
			end
			stq_pkg::OP_TAKE: res_entry_q <= rd_q;
			stq_pkg::OP_FLAG: res_status_q <= cmd.flag;
			default: ;
		endcase
	end

	// output register, holds until the transfer
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_count_q  <= fill_q;
		end
	end

	assign status          = out_status_q;
	assign out_id          = out_entry_q.id;
	assign out_expire_min  = out_entry_q.expire;
	assign out_deliver_min = out_entry_q.deliver;
	assign entry_count     = stq_pkg::COUNT_W'(out_count_q);

endmodule
`default_nettype wire

/* src/stq_ctrl.sv */
// controller: sequences one action over the entry memory
// depends on stq_pkg; commands stq_datapath
`default_nettype none
module stq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire stq_pkg::dp_stat_t  stat,
	output stq_pkg::dp_cmd_t        cmd
);

	stq_pkg::state_t state_q;
	stq_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stq_pkg::S_IDLE: begin
				if (in_valid) state_d = stq_pkg::S_DISPATCH;
			end
			stq_pkg::S_DISPATCH: begin
				case (stat.action)
					stq_pkg::ACT_INSERT:
						state_d = stat.full ? stq_pkg::S_DONE : stq_pkg::S_INS_CHK;
					stq_pkg::ACT_SUBTRACT: state_d = stq_pkg::S_SUB_CHK;
					default:
						state_d = stat.fill_zero ? stq_pkg::S_DONE : stq_pkg::S_SRCH_RD;
				endcase
			end
			stq_pkg::S_INS_CHK:
				state_d = stat.idx_zero ? stq_pkg::S_DONE : stq_pkg::S_INS_CMP;
			stq_pkg::S_INS_CMP:
				state_d = stat.key_gt ? stq_pkg::S_INS_CHK : stq_pkg::S_DONE;
			stq_pkg::S_SRCH_RD:
				state_d = stat.idx_at_fill ? stq_pkg::S_DONE : stq_pkg::S_SRCH_CMP;
			stq_pkg::S_SRCH_CMP: begin
				if (stat.action == stq_pkg::ACT_REMOVE_HEAD || stat.id_match) begin
					state_d = stq_pkg::S_SHF_CHK;
				end else begin
					state_d = stq_pkg::S_SRCH_RD;
				end
			end
			stq_pkg::S_SHF_CHK:
				state_d = stat.next_at_fill ? stq_pkg::S_DONE : stq_pkg::S_SHF_WR;
			stq_pkg::S_SHF_WR: state_d = stq_pkg::S_SHF_CHK;
			stq_pkg::S_SUB_CHK:
				state_d = stat.idx_at_fill ? stq_pkg::S_DONE : stq_pkg::S_SUB_WR;
			stq_pkg::S_SUB_WR: state_d = stq_pkg::S_SUB_CHK;
			stq_pkg::S_DONE: begin
				if (out_free) state_d = stq_pkg::S_IDLE;
			end
			default: state_d = stq_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '{op: stq_pkg::OP_NONE, rd_en: 1'b0, rd_sel: stq_pkg::RD_CUR,
			flag: stq_pkg::ST_OK, out_load: 1'b0};
		in_ready = 1'b0;
		case (state_q)
			stq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = stq_pkg::OP_LOAD;
			end
			stq_pkg::S_DISPATCH: begin
				if (stat.action == stq_pkg::ACT_INSERT) begin
					if (stat.full) begin
						cmd.op   = stq_pkg::OP_FLAG;
						cmd.flag = stq_pkg::ST_FULL;
					end
				end else if (stat.action != stq_pkg::ACT_SUBTRACT && stat.fill_zero) begin
					cmd.op   = stq_pkg::OP_FLAG;
					cmd.flag = stq_pkg::ST_EMPTY;
				end
			end
			stq_pkg::S_INS_CHK: begin
				if (stat.idx_zero) begin
					cmd.op = stq_pkg::OP_PLACE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = stq_pkg::RD_PREV;
				end
			end
			stq_pkg::S_INS_CMP:
				cmd.op = stat.key_gt ? stq_pkg::OP_MOVE_UP : stq_pkg::OP_PLACE;
			stq_pkg::S_SRCH_RD: begin
				if (stat.idx_at_fill) begin
					cmd.op   = stq_pkg::OP_FLAG;
					cmd.flag = stq_pkg::ST_NOTFOUND;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			stq_pkg::S_SRCH_CMP: begin
				if (stat.action == stq_pkg::ACT_REMOVE_HEAD || stat.id_match) begin
					cmd.op = stq_pkg::OP_TAKE;
				end else begin
					cmd.op = stq_pkg::OP_NEXT;
				end
			end
			stq_pkg::S_SHF_CHK: begin
				if (stat.next_at_fill) begin
					cmd.op = stq_pkg::OP_DROP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = stq_pkg::RD_NEXT;
				end
			end
			stq_pkg::S_SHF_WR: cmd.op = stq_pkg::OP_SHIFT;
			stq_pkg::S_SUB_CHK: cmd.rd_en = !stat.idx_at_fill;
			stq_pkg::S_SUB_WR: cmd.op = stq_pkg::OP_SUB;
			stq_pkg::S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/sorted_timer_priority_queue.sv */
// top level: apb configuration registers, controller and datapath
// depends on stq_pkg, stq_in_if, stq_out_if, stq_ctrl, stq_datapath
`default_nettype none
// Sorted timer queue of up to 16 entries (id, expiry and delivery minutes),
// kept packed in ascending key order in a single-port-read entry memory.
// One action is handled at a time; each returns one result. The walk reads the
// slots it touches through a registered read port. Insert moves each entry
// with a larger key one slot toward the tail, then places the new entry;
// remove searches from the head and shifts the later entries toward the head;
// subtract walks every entry. A new action is taken while the previous result
// still waits at the output. Configuration (sort key at 0x0, capacity at 0x4)
// is to be written by the user only while idle; the block itself does not enforce it.
module sorted_timer_priority_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	stq_in_if.sink                             in_ch,
	stq_out_if.source                          out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [stq_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [stq_pkg::DATA_W-1:0]    pwdata,
	output logic [stq_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	logic                          sort_key_q;
	logic [stq_pkg::LIMIT_W-1:0]   cap_limit_q;
	stq_pkg::reg_idx_t             reg_idx;
	logic                          cfg_wr;
	stq_pkg::dp_cmd_t              cmd;
	stq_pkg::dp_stat_t             stat;

	// apb register file
	assign pready  = 1'b1;
	assign reg_idx = stq_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q  <= 1'b0;
			cap_limit_q <= stq_pkg::LIMIT_W'(stq_pkg::DEPTH);
		end else if (cfg_wr) begin
			case (reg_idx)
				stq_pkg::REG_SORT_KEY: sort_key_q <= pwdata[0];
				stq_pkg::REG_CAPACITY: cap_limit_q <= pwdata[stq_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			stq_pkg::REG_SORT_KEY: prdata = stq_pkg::DATA_W'(sort_key_q);
			stq_pkg::REG_CAPACITY: prdata = stq_pkg::DATA_W'(cap_limit_q);
			default:               prdata = '0;
		endcase
	end

	// sequencer
	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// entry storage and arithmetic
	stq_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (in_ch.action),
		.in_id           (in_ch.in_id),
		.in_expire_min   (in_ch.in_expire_min),
		.in_deliver_min  (in_ch.in_deliver_min),
		.minutes_delta   (in_ch.minutes_delta),
		.time_field      (in_ch.time_field),
		.sort_key        (sort_key_q),
		.cap_limit       (cap_limit_q),
		.stat            (stat),
		.status          (out_ch.status),
		.out_id          (out_ch.out_id),
		.out_expire_min  (out_ch.out_expire_min),
		.out_deliver_min (out_ch.out_deliver_min),
		.entry_count     (out_ch.entry_count)
	);

`ifndef ASSERT_OFF
	// fill never passes the memory depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= stq_pkg::CNT_W'(stq_pkg::DEPTH))
		else $error("fill count above depth");

	// one action at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while busy");

	// flagged results carry no entry
	a_flag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != stq_pkg::ST_OK |-> out_ch.out_id == '0
		&& out_ch.out_expire_min == '0 && out_ch.out_deliver_min == '0)
		else $error("flagged result with entry data");
`endif

endmodule
`default_nettype wire
